/* sv/pic8259_pkg.sv */
// Shared types and codes for the 8259-style interrupt controller.
// No dependencies; imported by the grant, core and top-level modules.
package pic8259_pkg;

    // Operation codes of one input item
    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_RAISE = 3'd2;
    localparam logic [2:0] OP_LOWER = 3'd3;
    localparam logic [2:0] OP_ACK   = 3'd4;

    // Error codes returned on register writes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_ICW1      = 3'd1;
    localparam logic [2:0] ERR_NO_COMP   = 3'd2;
    localparam logic [2:0] ERR_ICW2      = 3'd3;
    localparam logic [2:0] ERR_ICW3      = 3'd4;
    localparam logic [2:0] ERR_ICW4      = 3'd5;
    localparam logic [2:0] ERR_NOT_READY = 3'd6;
    localparam logic [2:0] ERR_OCW       = 3'd7;

    // Initialization steps
    localparam logic [2:0] STEP_READY = 3'd0;
    localparam logic [2:0] STEP_ICW1  = 3'd1;
    localparam logic [2:0] STEP_ICW2  = 3'd2;
    localparam logic [2:0] STEP_ICW3  = 3'd3;
    localparam logic [2:0] STEP_ICW4  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_HAS_COMPANION = 1'b0;
    localparam logic CFG_IS_SLAVE      = 1'b1;

    // Command words and bit positions
    localparam logic [7:0] CMD_NS_EOI     = 8'h20;
    localparam logic [3:0] CMD_SP_EOI_HI  = 4'h6;
    localparam logic [7:0] ICW1_FIXED_MSK = 8'hed;
    localparam logic [7:0] ICW1_FIXED_VAL = 8'h01;
    localparam logic [7:0] ICW4_FIXED_MSK = 8'hf7;
    localparam logic [7:0] ICW4_FIXED_VAL = 8'h01;
    localparam logic [2:0] RSEL_IRR       = 3'b010;
    localparam logic [2:0] RSEL_ISR       = 3'b011;
    localparam int         ICW1_INIT      = 4;
    localparam int         ICW1_SINGLE    = 1;
    localparam int         ICW1_NEED4     = 0;
    localparam int         OCW3_SEL       = 3;

    // One input item
    typedef struct packed {
        logic [2:0] operation;
        logic       offset;
        logic [7:0] write_data;
        logic [2:0] line;
    } item_t;

    // One result item
    typedef struct packed {
        logic [7:0] read_data;
        logic       vector_valid;
        logic [7:0] vector;
        logic       cascade_ack;
        logic       forward_raise;
        logic [7:0] forward_line;
        logic [2:0] error_code;
    } result_t;

    // Priority resolver answer
    typedef struct packed {
        logic       valid;
        logic [2:0] index;
    } grant_t;

endpackage

/* sv/pic8259_grant.sv */
// Fixed-priority resolver: line 0 highest, an in-service line blocks lower ones.
// Depends on pic8259_pkg for grant_t.
module pic8259_grant
(
    input  logic [7:0]            pending,
    input  logic [7:0]            service,
    output pic8259_pkg::grant_t   grant
);
    import pic8259_pkg::*;

    // Scan from line 0; stop at the first in-service or pending line
    always_comb
    begin
        logic done;
        done  = 1'b0;
        grant = '0;
        if (pending != 8'd0)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (!done)
                begin
                    if (service[i])
                    begin
                        done = 1'b1;
                    end
                    else if (pending[i])
                    begin
                        done        = 1'b1;
                        grant.valid = 1'b1;
                        grant.index = 3'(i);
                    end
                end
            end
        end
    end

endmodule

/* sv/pic8259_core.sv */
// Controller state (ICWs, IRR, ISR, IMR, read select, config) and per-item update.
// Depends on pic8259_pkg and pic8259_grant.
module pic8259_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic                  cfg_data,
    input  logic                  go,
    input  pic8259_pkg::item_t    item,
    output pic8259_pkg::result_t  result
);
    import pic8259_pkg::*;

    logic       has_comp_reg;
    logic       is_slave_reg;
    logic [2:0] step_reg,  step_next;
    logic [7:0] icw1_reg,  icw1_next;
    logic [7:0] base_reg,  base_next;
    logic [7:0] casc_reg,  casc_next;
    logic [7:0] irr_reg,   irr_next;
    logic [7:0] isr_reg,   isr_next;
    logic [7:0] imr_reg,   imr_next;
    logic       rsel_reg,  rsel_next;
    grant_t     grant;

    pic8259_grant u_grant
    (
        .pending (irr_reg & ~imr_reg),
        .service (isr_reg),
        .grant   (grant)
    );

    // Work out next state and the result for the current item
    always_comb
    begin
        logic [7:0] v;
        logic [2:0] after23;
        logic [7:0] bitmask;
        v         = item.write_data;
        after23   = icw1_reg[ICW1_NEED4] ? STEP_ICW4 : STEP_READY;
        bitmask   = 8'd1 << item.line;
        step_next = step_reg;
        icw1_next = icw1_reg;
        base_next = base_reg;
        casc_next = casc_reg;
        irr_next  = irr_reg;
        isr_next  = isr_reg;
        imr_next  = imr_reg;
        rsel_next = rsel_reg;
        result    = '0;
        case (item.operation)
            OP_READ:
            begin
                if (!item.offset)
                    result.read_data = rsel_reg ? isr_reg : irr_reg;
                else
                    result.read_data = imr_reg;
            end
            OP_WRITE:
            begin
                if (!item.offset)
                begin
                    if (v[ICW1_INIT])
                    begin
                        if ((v & ICW1_FIXED_MSK) != ICW1_FIXED_VAL)
                            result.error_code = ERR_ICW1;
                        else if (!v[ICW1_SINGLE] && !has_comp_reg)
                            result.error_code = ERR_NO_COMP;
                        else
                        begin
                            icw1_next = v;
                            step_next = STEP_ICW2;
                        end
                    end
                    else if (v[OCW3_SEL])
                    begin
                        if (v[2:0] == RSEL_IRR)
                            rsel_next = 1'b0;
                        else if (v[2:0] == RSEL_ISR)
                            rsel_next = 1'b1;
                        else
                            result.error_code = ERR_OCW;
                    end
                    else if (v == CMD_NS_EOI)
                        isr_next = isr_reg & (isr_reg - 8'd1);
                    else if (v[7:4] == CMD_SP_EOI_HI)
                        isr_next = isr_reg & ~(8'd1 << v[2:0]);
                    else
                        result.error_code = ERR_OCW;
                end
                else
                begin
                    case (step_reg)
                        STEP_READY:
                            imr_next = v;
                        STEP_ICW2:
                        begin
                            if (v[2:0] != 3'd0)
                                result.error_code = ERR_ICW2;
                            else
                            begin
                                base_next = v;
                                step_next = icw1_reg[ICW1_SINGLE] ? after23 : STEP_ICW3;
                            end
                        end
                        STEP_ICW3:
                        begin
                            casc_next = v;
                            step_next = after23;
                            if (is_slave_reg ? (v > 8'd7)
                                             : (v == 8'd0 || (v & (v - 8'd1)) != 8'd0))
                                result.error_code = ERR_ICW3;
                        end
                        STEP_ICW4:
                        begin
                            step_next = STEP_READY;
                            if ((v & ICW4_FIXED_MSK) != ICW4_FIXED_VAL)
                                result.error_code = ERR_ICW4;
                        end
                        default:
                            result.error_code = ERR_NOT_READY;
                    endcase
                end
            end
            OP_RAISE:
            begin
                irr_next = irr_reg | bitmask;
                if (!icw1_reg[ICW1_SINGLE] && is_slave_reg && has_comp_reg)
                begin
                    result.forward_raise = 1'b1;
                    result.forward_line  = casc_reg;
                end
            end
            OP_LOWER:
                irr_next = irr_reg & ~bitmask;
            OP_ACK:
            begin
                if (step_reg == STEP_READY && grant.valid)
                begin
                    irr_next = irr_reg & ~(8'd1 << grant.index);
                    isr_next = isr_reg | (8'd1 << grant.index);
                    if (has_comp_reg && !is_slave_reg && casc_reg[grant.index])
                        result.cascade_ack = 1'b1;
                    else
                    begin
                        result.vector_valid = 1'b1;
                        result.vector       = {base_reg[7:3], base_reg[2:0] | grant.index};
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    // Hold configuration until written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_comp_reg <= 1'b0;
            is_slave_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_HAS_COMPANION)
                has_comp_reg <= cfg_data;
            else
                is_slave_reg <= cfg_data;
        end
    end

    // Advance controller state once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_ICW1;
            icw1_reg <= 8'd0;
            base_reg <= 8'd0;
            casc_reg <= 8'd0;
            irr_reg  <= 8'd0;
            isr_reg  <= 8'd0;
            imr_reg  <= 8'hff;
            rsel_reg <= 1'b0;
        end
        else if (go)
        begin
            step_reg <= step_next;
            icw1_reg <= icw1_next;
            base_reg <= base_next;
            casc_reg <= casc_next;
            irr_reg  <= irr_next;
            isr_reg  <= isr_next;
            imr_reg  <= imr_next;
            rsel_reg <= rsel_next;
        end
    end

endmodule

/* sv/interrupt_controller_8259.sv */
// Top level of the 8259-style interrupt controller: input register, core, result register.
// Depends on pic8259_pkg and pic8259_core.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------------
//  in       | in_valid / in_stall        | operation, offset, write_data, line
//  out      | out_valid / out_stall      | read_data, vector_valid, vector, cascade_ack,
//           |                            | forward_raise, forward_line, error_code
//  cfg      | cfg_write                  | cfg_index, cfg_data
//
// One item per cycle while the result register can take it: an item is held in the input
// register, processed by the core in a single pass, and its result is then registered.
// Reset puts the controller back to awaiting ICW1 with all lines masked.
// When out_stall holds the result register full, the input register holds its item and
// in_stall rises; a new transfer is taken as soon as the result register drains.
module interrupt_controller_8259
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] operation,
    input  logic       offset,
    input  logic [7:0] write_data,
    input  logic [2:0] line,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic       vector_valid,
    output logic [7:0] vector,
    output logic       cascade_ack,
    output logic       forward_raise,
    output logic [7:0] forward_line,
    output logic [2:0] error_code
);
    import pic8259_pkg::*;

    logic    in_vld_reg;
    item_t   item_reg;
    logic    out_vld_reg;
    result_t res_reg;
    result_t res_next;
    logic    advance;

    // Move the held item into the result register when that register is free
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;

    pic8259_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .go        (advance),
        .item      (item_reg),
        .result    (res_next)
    );

    // Capture an input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            item_reg <= '{operation: operation, offset: offset,
                          write_data: write_data, line: line};
    end

    // Hold the result until the output transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid     = out_vld_reg;
    assign read_data     = res_reg.read_data;
    assign vector_valid  = res_reg.vector_valid;
    assign vector        = res_reg.vector;
    assign cascade_ack   = res_reg.cascade_ack;
    assign forward_raise = res_reg.forward_raise;
    assign forward_line  = res_reg.forward_line;
    assign error_code    = res_reg.error_code;

endmodule
